/* rtl/core/sinusoidal_stepper_stroke_sequencer_defines.svh */
// Assertion macros shared by the stroke sequencer RTL.
`ifndef SINUSOIDAL_STEPPER_STROKE_SEQUENCER_DEFINES_SVH
`define SINUSOIDAL_STEPPER_STROKE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/sss_pkg.sv */
// Types, register codes and sine table builder for the stroke sequencer.
`timescale 1ns / 1ps
`default_nettype none

package sss_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int DELAY_W     = 16;
    localparam int POS_W       = 16;

    typedef enum logic [2:0] {
        PH_SYS_ACC  = 3'd0,
        PH_SYS_DEC  = 3'd1,
        PH_DIA_ACC  = 3'd2,
        PH_DIA_DEC  = 3'd3,
        PH_RETURN   = 3'd4,
        PH_DONE     = 3'd5,
        PH_SHUTDOWN = 3'd6,
        PH_HOLD     = 3'd7
    } phase_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_SYS_FAST  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYS_SLOW  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIA_FAST  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIA_SLOW  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETURN    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PARK      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUNTIME   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOME_TOL  = 3'd7;

    localparam logic [15:0] RST_SYS_FAST = 16'd1;
    localparam logic [15:0] RST_SYS_SLOW = 16'd300;
    localparam logic [15:0] RST_DIA_FAST = 16'd15;
    localparam logic [15:0] RST_DIA_SLOW = 16'd400;
    localparam logic [15:0] RST_RETURN   = 16'd40;
    localparam logic [15:0] RST_PARK     = 16'd250;
    localparam logic [31:0] RST_RUNTIME  = 32'd2700000;
    localparam logic [7:0]  RST_HOME_TOL = 8'd5;

    // pi/2 in Q2.30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Taylor divisors (2k)(2k+1) for k = 1..7
    localparam logic [63:0] TAYLOR_DIV [7] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    // Elaboration-time sine of a Q2.30 angle, rounded to frac bits, capped at 1.0
    function automatic logic [63:0] sss_sine_q(input logic [63:0] x, input int frac);
        logic        [63:0] x2;
        logic        [63:0] term;
        logic        [63:0] r;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int k = 0; k < 7; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if ((k % 2) == 0) begin
                sum = sum - signed'(term);
            end
            else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        r = (unsigned'(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
        if (r > (64'd1 << frac)) begin
            r = 64'd1 << frac;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/sss_sine_rom.sv */
// Quarter-sine ROM with registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sss_sine_rom #(
    parameter int TABLE_SIZE     = 600,
    parameter int SINE_FRAC_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
    output logic      [SINE_FRAC_BITS:0]       rd_data
);
    import sss_pkg::*;

    localparam int DW = SINE_FRAC_BITS + 1;

    localparam logic [63:0] ENTRY0_FULL = sss_sine_q(64'd0, SINE_FRAC_BITS);
    localparam logic [DW-1:0] ENTRY0 = ENTRY0_FULL[DW-1:0];

    logic [DW-1:0] rom_tab [TABLE_SIZE];
    logic [DW-1:0] data_reg;

    for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
        localparam logic [63:0] ANGLE = (HALF_PI_Q30 * 64'(g)) / 64'(TABLE_SIZE - 1);
        localparam logic [63:0] VALUE = sss_sine_q(ANGLE, SINE_FRAC_BITS);
        assign rom_tab[g] = VALUE[DW-1:0];
    end

    // entry 0 is what the first word after reset needs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= ENTRY0;
        end
        else if (rd_en)
        begin
            data_reg <= rom_tab[rd_addr];
        end
    end

    assign rd_data = data_reg;

endmodule

`default_nettype wire

/* rtl/core/sss_profile_delay.sv */
// Step interval from the fast/slow pair and a quarter-sine sample.
`timescale 1ns / 1ps
`default_nettype none

module sss_profile_delay #(
    parameter int SINE_FRAC_BITS = 16
) (
    input  wire logic [sss_pkg::DELAY_W-1:0] fast,
    input  wire logic [sss_pkg::DELAY_W-1:0] slow,
    input  wire logic [SINE_FRAC_BITS:0]     sine,
    output logic      [sss_pkg::DELAY_W-1:0] delay
);
    import sss_pkg::*;

    localparam int DW = SINE_FRAC_BITS + 1;
    localparam int PW = DELAY_W + DW;
    localparam logic [PW:0] ROUND_UP = (PW + 1)'((64'd1 << SINE_FRAC_BITS) - 64'd1);

    logic [DELAY_W-1:0]          span;
    logic [PW-1:0]               prod;
    logic [PW:0]                 prod_up;
    logic [PW-SINE_FRAC_BITS:0]  dec;
    logic [DELAY_W-1:0]          raw;

    assign span    = slow - fast;
    assign prod    = PW'(span) * PW'(sine);
    assign prod_up = {1'b0, prod} + ROUND_UP;
    assign dec     = prod_up[PW:SINE_FRAC_BITS];

    always_comb
    begin
        if (dec > (PW - SINE_FRAC_BITS + 1)'(slow))
        begin
            raw = '0;
        end
        else
        begin
            raw = slow - dec[DELAY_W-1:0];
        end
        // clamp into [fast, slow]; an inverted pair runs at slow
        priority if (slow < fast)
        begin
            delay = slow;
        end
        else if (raw < fast)
        begin
            delay = fast;
        end
        else if (raw > slow)
        begin
            delay = slow;
        end
        else
        begin
            delay = raw;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sinusoidal_stepper_stroke_sequencer.sv */
// Top level: stroke sequencer state, config registers and result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in      | input     | in_valid / in_ready  | now_us, now_ms
//  out     | output    | out_valid / out_ready| step_pulse, direction_cw, position,
//          |           |                      | phase, shutdown_pending
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One word per cycle: each accepted timestamp runs through one pass of step logic
// (sine sample, one multiply, elapsed-time compare) into the result register.
// The sine sample for the next word is read from the ROM at the same edge that
// updates the state, so the ROM read latency stays hidden.
// Reset takes effect at once; no clearing pass.
// A result not taken stalls in_ready; while out_ready is high a word moves every cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "sinusoidal_stepper_stroke_sequencer_defines.svh"

module sinusoidal_stepper_stroke_sequencer #(
    parameter int TABLE_SIZE     = 600,
    parameter int SINE_FRAC_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [31:0]                       now_us,
    input  wire logic [31:0]                       now_ms,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   step_pulse,
    output logic                                   direction_cw,
    output logic signed [sss_pkg::POS_W-1:0]       position,
    output logic [2:0]                             phase,
    output logic                                   shutdown_pending,
    input  wire logic                              cfg_we,
    input  wire logic [sss_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [sss_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sss_pkg::*;

    localparam int DW   = SINE_FRAC_BITS + 1;
    localparam int AW   = $clog2(TABLE_SIZE);
    localparam int HALF = TABLE_SIZE / 2;
    localparam int SW   = $clog2(HALF + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SIZE - 1);
    localparam logic [SW:0]   HALF_CNT = (SW + 1)'(HALF);

    // configuration
    logic [15:0] sys_fast_reg, sys_slow_reg, dia_fast_reg, dia_slow_reg;
    logic [15:0] return_delay_reg, park_delay_reg;
    logic [31:0] runtime_reg;
    logic [7:0]  home_tol_reg;

    // sequencer state
    phase_t          phase_reg, phase_next;
    logic [SW-1:0]   step_reg, step_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]     remain_reg, remain_next;
    logic            dir_reg, dir_next;
    logic [31:0]     last_step_reg, last_step_next;
    logic [31:0]     start_ms_reg, start_ms_next;
    logic            started_reg;
    logic            shutdown_reg, shutdown_next;

    // result register
    logic            out_valid_reg;
    logic            pulse_out_reg;
    logic            dir_out_reg;
    logic [POS_W-1:0] pos_out_reg;
    phase_t          phase_out_reg;
    logic            shut_out_reg;

    logic            in_fire;
    logic            stepped;
    logic            is_stroke, is_systole;
    logic [15:0]     prof_fast, prof_slow, prof_delay, delay_sel;
    logic [DW-1:0]   sine_q;
    logic [AW-1:0]   rom_addr;
    logic [31:0]     elapsed;
    logic            step_ok;
    logic [POS_W:0]  pos_abs, stepped_abs;
    logic            pos_positive, stepped_positive;
    logic            step_cw;
    logic [POS_W-1:0] pos_stepped;
    logic [SW:0]     step_inc;
    logic            stroke_end;
    logic            home_return, home_park;

    assign in_fire  = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_fast_reg     <= RST_SYS_FAST;
            sys_slow_reg     <= RST_SYS_SLOW;
            dia_fast_reg     <= RST_DIA_FAST;
            dia_slow_reg     <= RST_DIA_SLOW;
            return_delay_reg <= RST_RETURN;
            park_delay_reg   <= RST_PARK;
            runtime_reg      <= RST_RUNTIME;
            home_tol_reg     <= RST_HOME_TOL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYS_FAST: sys_fast_reg     <= cfg_data[15:0];
                CFG_SYS_SLOW: sys_slow_reg     <= cfg_data[15:0];
                CFG_DIA_FAST: dia_fast_reg     <= cfg_data[15:0];
                CFG_DIA_SLOW: dia_slow_reg     <= cfg_data[15:0];
                CFG_RETURN:   return_delay_reg <= cfg_data[15:0];
                CFG_PARK:     park_delay_reg   <= cfg_data[15:0];
                CFG_RUNTIME:  runtime_reg      <= cfg_data[31:0];
                CFG_HOME_TOL: home_tol_reg     <= cfg_data[7:0];
            endcase
        end
    end

    // shared step logic
    assign is_stroke  = (phase_reg == PH_SYS_ACC) || (phase_reg == PH_SYS_DEC) ||
                        (phase_reg == PH_DIA_ACC) || (phase_reg == PH_DIA_DEC);
    assign is_systole = (phase_reg == PH_SYS_ACC) || (phase_reg == PH_SYS_DEC);
    assign prof_fast  = is_systole ? sys_fast_reg : dia_fast_reg;
    assign prof_slow  = is_systole ? sys_slow_reg : dia_slow_reg;

    sss_profile_delay #(
        .SINE_FRAC_BITS(SINE_FRAC_BITS)
    ) u_profile (
        .fast  (prof_fast),
        .slow  (prof_slow),
        .sine  (sine_q),
        .delay (prof_delay)
    );

    always_comb
    begin
        unique case (phase_reg)
            PH_RETURN:   delay_sel = return_delay_reg;
            PH_SHUTDOWN: delay_sel = park_delay_reg;
            default:     delay_sel = prof_delay;
        endcase
    end

    assign start_ms_next = started_reg ? start_ms_reg : now_ms;
    assign shutdown_next = shutdown_reg || ((now_ms - start_ms_next) >= runtime_reg);

    assign elapsed = now_us - last_step_reg;
    assign step_ok = elapsed >= {16'd0, delay_sel};

    assign pos_abs      = pos_reg[POS_W-1] ? ((POS_W + 1)'(0) - {1'b1, pos_reg})
                                           : {1'b0, pos_reg};
    assign pos_positive = !pos_reg[POS_W-1] && (pos_reg != '0);
    assign step_cw      = is_stroke ? is_systole : pos_positive;
    assign pos_stepped  = step_cw ? (pos_reg - POS_W'(1)) : (pos_reg + POS_W'(1));

    assign stepped_abs      = pos_stepped[POS_W-1]
                              ? ((POS_W + 1)'(0) - {1'b1, pos_stepped})
                              : {1'b0, pos_stepped};
    assign stepped_positive = !pos_stepped[POS_W-1] && (pos_stepped != '0);

    assign step_inc    = {1'b0, step_reg} + (SW + 1)'(1);
    assign stroke_end  = step_inc >= HALF_CNT;
    assign home_return = (pos_reg == '0) || (pos_abs < (POS_W + 1)'(home_tol_reg));
    assign home_park   = !(pos_abs > (POS_W + 1)'(home_tol_reg));

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_SYS_ACC:
                if (step_ok && stroke_end) phase_next = PH_SYS_DEC;
            PH_SYS_DEC:
                if (step_ok && stroke_end) phase_next = PH_DIA_ACC;
            PH_DIA_ACC:
                if (step_ok && stroke_end) phase_next = PH_DIA_DEC;
            PH_DIA_DEC:
                if (step_ok && stroke_end)
                begin
                    priority if (shutdown_next)       phase_next = PH_SHUTDOWN;
                    else if (pos_stepped != '0)        phase_next = PH_RETURN;
                    else                               phase_next = PH_DONE;
                end
            PH_RETURN:
                if ((remain_reg == '0) && home_return)
                    phase_next = shutdown_next ? PH_SHUTDOWN : PH_DONE;
            PH_DONE:
                phase_next = shutdown_next ? PH_SHUTDOWN : PH_SYS_ACC;
            PH_SHUTDOWN:
                if (home_park) phase_next = PH_HOLD;
            PH_HOLD:
                phase_next = PH_HOLD;
        endcase
    end

    // datapath updates
    always_comb
    begin
        stepped        = 1'b0;
        step_next      = step_reg;
        pos_next       = pos_reg;
        remain_next    = remain_reg;
        dir_next       = dir_reg;
        last_step_next = last_step_reg;
        unique case (phase_reg)
            PH_SYS_ACC, PH_SYS_DEC, PH_DIA_ACC, PH_DIA_DEC:
            begin
                if (step_ok)
                begin
                    stepped        = 1'b1;
                    pos_next       = pos_stepped;
                    last_step_next = now_us;
                    step_next      = stroke_end ? '0 : step_inc[SW-1:0];
                    if (stroke_end && (phase_reg == PH_SYS_DEC))
                    begin
                        dir_next = 1'b0;
                    end
                    if (stroke_end && (phase_reg == PH_DIA_DEC) && !shutdown_next)
                    begin
                        if (pos_stepped != '0)
                        begin
                            remain_next = stepped_abs[15:0];
                            dir_next    = stepped_positive;
                        end
                        else
                        begin
                            dir_next = 1'b1;
                        end
                    end
                end
            end
            PH_RETURN:
            begin
                priority if (remain_reg != '0)
                begin
                    dir_next = pos_positive;
                    if (step_ok)
                    begin
                        stepped        = 1'b1;
                        pos_next       = pos_stepped;
                        last_step_next = now_us;
                        remain_next    = remain_reg - 16'd1;
                    end
                end
                else if (home_return)
                begin
                    pos_next = '0;
                    if (!shutdown_next)
                    begin
                        dir_next  = 1'b1;
                        step_next = '0;
                    end
                end
                else
                begin
                    remain_next = pos_abs[15:0];
                    dir_next    = pos_positive;
                end
            end
            PH_SHUTDOWN:
            begin
                if (!home_park)
                begin
                    dir_next    = pos_positive;
                    remain_next = pos_abs[15:0];
                    if (step_ok)
                    begin
                        stepped        = 1'b1;
                        pos_next       = pos_stepped;
                        last_step_next = now_us;
                        remain_next    = pos_abs[15:0] - 16'd1;
                    end
                end
                else
                begin
                    pos_next = '0;
                end
            end
            PH_DONE, PH_HOLD:
            begin
            end
        endcase
    end

    // prefetch the sine sample that the next word will use
    assign rom_addr = ((phase_next == PH_SYS_DEC) || (phase_next == PH_DIA_DEC))
                      ? (LAST_IDX - AW'(step_next)) : AW'(step_next);

    sss_sine_rom #(
        .TABLE_SIZE    (TABLE_SIZE),
        .SINE_FRAC_BITS(SINE_FRAC_BITS)
    ) u_rom (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (rom_addr),
        .rd_data (sine_q)
    );

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SYS_ACC;
            step_reg      <= '0;
            pos_reg       <= '0;
            remain_reg    <= '0;
            dir_reg       <= 1'b1;
            last_step_reg <= '0;
            start_ms_reg  <= '0;
            started_reg   <= 1'b0;
            shutdown_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg     <= phase_next;
                step_reg      <= step_next;
                pos_reg       <= pos_next;
                remain_reg    <= remain_next;
                dir_reg       <= dir_next;
                last_step_reg <= last_step_next;
                start_ms_reg  <= start_ms_next;
                started_reg   <= 1'b1;
                shutdown_reg  <= shutdown_next;
            end
            // hold the result until taken
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pulse_out_reg <= stepped;
            dir_out_reg   <= dir_next;
            pos_out_reg   <= pos_next;
            phase_out_reg <= phase_next;
            shut_out_reg  <= shutdown_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign step_pulse       = pulse_out_reg;
    assign direction_cw     = dir_out_reg;
    assign position         = signed'(pos_out_reg);
    assign phase            = phase_out_reg;
    assign shutdown_pending = shut_out_reg;

    `SSS_ASSERT_NEXT(a_hold_sticky, phase_reg == PH_HOLD, phase_reg == PH_HOLD,
        "hold phase was left without reset")
    `SSS_ASSERT_NEXT(a_shutdown_sticky, shutdown_reg, shutdown_reg,
        "shutdown flag cleared after it was set")
    `SSS_ASSERT_NOW(a_step_in_range, 1'b1, {1'b0, step_reg} < HALF_CNT,
        "step index reached the phase length")
    `SSS_ASSERT_NEXT(a_done_exit, in_fire && (phase_reg == PH_DONE),
        (phase_reg == PH_SYS_ACC) || (phase_reg == PH_SHUTDOWN),
        "cycle-done did not move to a new stroke or shutdown")
    `SSS_ASSERT_NOW(a_no_step_in_hold, out_valid_reg && (phase_out_reg == PH_HOLD),
        !pulse_out_reg, "step issued while holding")

endmodule

`default_nettype wire

/* test/sinusoidal_stepper_stroke_sequencer_test.sv */
// Self-checking bench for the stroke sequencer: predicted words against DUT words.
`timescale 1ns / 1ps

module sinusoidal_stepper_stroke_sequencer_test;
    import sss_pkg::*;

    localparam int STROKE_TABLE = 600;
    localparam int SINE_BITS = 16;
    localparam int HALF_STROKE = STROKE_TABLE / 2;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 50;
    localparam int STREAM_CAP = 4000;

    typedef enum int { STOP_COUNT, STOP_STROKE, STOP_HOLD } stream_end_t;

    typedef struct packed {
        logic        step;
        logic        dir;
        logic [15:0] pos;
        phase_t      stage;
        logic        shut;
    } stroke_word_t;

    class stroke_tracker;
        logic [15:0]       sys_fast, sys_slow, dia_fast, dia_slow, ret_dly, park_dly;
        logic [31:0]       run_ms;
        logic [7:0]        home_tol;
        phase_t            stage;
        int unsigned       step_idx;
        logic [15:0]       pos;
        int unsigned       ret_left;
        logic              dir;
        logic [31:0]       last_us;
        logic [31:0]       start_ms;
        bit                started;
        bit                shut;
        int unsigned       strokes;
        int unsigned       mismatches;
        int unsigned       words_seen;
        longint unsigned   sine_q [STROKE_TABLE];
        stroke_word_t      due_words [$];

        function new();
            sys_fast = RST_SYS_FAST;
            sys_slow = RST_SYS_SLOW;
            dia_fast = RST_DIA_FAST;
            dia_slow = RST_DIA_SLOW;
            ret_dly = RST_RETURN;
            park_dly = RST_PARK;
            run_ms = RST_RUNTIME;
            home_tol = RST_HOME_TOL;
            stage = PH_SYS_ACC;
            step_idx = 0;
            pos = '0;
            ret_left = 0;
            dir = 1'b1;
            last_us = '0;
            start_ms = '0;
            started = 0;
            shut = 0;
            strokes = 0;
            mismatches = 0;
            words_seen = 0;
            build_sine();
        endfunction

        // Taylor series to the x^15 term in Q2.30, rounded to SINE_BITS, capped at 1.0
        function void build_sine();
            longint unsigned x, x2, term, r;
            longint          sum;
            for (int i = 0; i < STROKE_TABLE; i++)
            begin
                x = (QUARTER_TURN_Q30 * 64'(i)) / 64'(STROKE_TABLE - 1);
                x2 = (x * x) >> 30;
                term = x;
                sum = longint'(x);
                for (int k = 1; k <= 7; k++)
                begin
                    term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                    if (k % 2 == 1)
                        sum = sum - longint'(term);
                    else
                        sum = sum + longint'(term);
                end
                if (sum < 0)
                    sum = 0;
                r = (unsigned'(sum) + (64'd1 << (29 - SINE_BITS))) >> (30 - SINE_BITS);
                if (r > (64'd1 << SINE_BITS))
                    r = 64'd1 << SINE_BITS;
                sine_q[i] = r;
            end
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SYS_FAST: sys_fast = data[15:0];
                CFG_SYS_SLOW: sys_slow = data[15:0];
                CFG_DIA_FAST: dia_fast = data[15:0];
                CFG_DIA_SLOW: dia_slow = data[15:0];
                CFG_RETURN:   ret_dly = data[15:0];
                CFG_PARK:     park_dly = data[15:0];
                CFG_RUNTIME:  run_ms = data[31:0];
                CFG_HOME_TOL: home_tol = data[7:0];
                default: ;
            endcase
        endfunction

        function int unsigned stroke_delay(logic [15:0] fast, logic [15:0] slow,
                                           int unsigned idx);
            longint unsigned prod, dec, d;
            if (slow < fast)
                return slow;
            prod = 64'(slow - fast) * sine_q[idx];
            dec = (prod + (64'd1 << SINE_BITS) - 1) >> SINE_BITS;
            d = (dec > slow) ? 0 : slow - dec;
            if (d < fast)
                d = fast;
            if (d > slow)
                d = slow;
            return 32'(d);
        endfunction

        // Step interval that applies to the next word
        function int unsigned pace();
            int unsigned idx;
            idx = (stage == PH_SYS_DEC || stage == PH_DIA_DEC) ?
                  STROKE_TABLE - 1 - step_idx : step_idx;
            case (stage)
                PH_SYS_ACC, PH_SYS_DEC: return stroke_delay(sys_fast, sys_slow, idx);
                PH_DIA_ACC, PH_DIA_DEC: return stroke_delay(dia_fast, dia_slow, idx);
                PH_RETURN:              return ret_dly;
                PH_SHUTDOWN:            return park_dly;
                default:                return 0;
            endcase
        endfunction

        function int pos_val();
            return int'($signed(pos));
        endfunction

        function int unsigned pos_mag();
            int v;
            v = pos_val();
            return (v < 0) ? -v : v;
        endfunction

        function bit take_step(logic [31:0] us, int unsigned gap_min, bit cw);
            logic [31:0] gap;
            gap = us - last_us;
            if (gap < gap_min)
                return 0;
            pos = cw ? pos - 16'd1 : pos + 16'd1;
            last_us = us;
            return 1;
        endfunction

        function void accept_timestamp(logic [31:0] us, logic [31:0] ms);
            stroke_word_t w;
            bit           stepped;
            bit           cw;
            stepped = 0;
            if (!started)
            begin
                start_ms = ms;
                started = 1;
            end
            if (!shut && ((ms - start_ms) >= run_ms))
                shut = 1;
            case (stage)
                PH_SYS_ACC, PH_SYS_DEC, PH_DIA_ACC, PH_DIA_DEC:
                begin
                    cw = (stage == PH_SYS_ACC || stage == PH_SYS_DEC);
                    if (take_step(us, pace(), cw))
                    begin
                        stepped = 1;
                        step_idx++;
                        if (step_idx >= HALF_STROKE)
                        begin
                            step_idx = 0;
                            case (stage)
                                PH_SYS_ACC: stage = PH_SYS_DEC;
                                PH_SYS_DEC:
                                begin
                                    dir = 1'b0;
                                    stage = PH_DIA_ACC;
                                end
                                PH_DIA_ACC: stage = PH_DIA_DEC;
                                default:
                                begin
                                    if (shut)
                                    begin
                                        stage = PH_SHUTDOWN;
                                    end
                                    else if (pos != 0)
                                    begin
                                        stage = PH_RETURN;
                                        ret_left = pos_mag();
                                        dir = pos_val() > 0;
                                    end
                                    else
                                    begin
                                        stage = PH_DONE;
                                        dir = 1'b1;
                                        strokes++;
                                    end
                                end
                            endcase
                        end
                    end
                end
                PH_RETURN:
                begin
                    if (ret_left > 0)
                    begin
                        dir = pos_val() > 0;
                        if (take_step(us, ret_dly, dir))
                        begin
                            stepped = 1;
                            ret_left--;
                        end
                    end
                    else if (pos == 0 || pos_mag() < home_tol)
                    begin
                        pos = '0;
                        if (shut)
                        begin
                            stage = PH_SHUTDOWN;
                        end
                        else
                        begin
                            stage = PH_DONE;
                            dir = 1'b1;
                            step_idx = 0;
                        end
                    end
                    else
                    begin
                        ret_left = pos_mag();
                        dir = pos_val() > 0;
                    end
                end
                PH_DONE: stage = shut ? PH_SHUTDOWN : PH_SYS_ACC;
                PH_SHUTDOWN:
                begin
                    // park toward home, then hold for good
                    if (pos_mag() > home_tol)
                    begin
                        ret_left = pos_mag();
                        dir = pos_val() > 0;
                        if (take_step(us, park_dly, dir))
                        begin
                            stepped = 1;
                            ret_left--;
                        end
                    end
                    else
                    begin
                        pos = '0;
                        stage = PH_HOLD;
                    end
                end
                default: ;
            endcase
            w.step = stepped;
            w.dir = dir;
            w.pos = pos;
            w.stage = stage;
            w.shut = shut;
            due_words.push_back(w);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch: %s", what);
        endtask

        task check_word(logic step_o, logic dir_o, logic [15:0] pos_o, logic [2:0] stage_o,
                        logic shut_o);
            stroke_word_t w;
            words_seen++;
            if (due_words.size() == 0)
            begin
                report($sformatf("word %0d arrived with none expected", words_seen));
                return;
            end
            w = due_words.pop_front();
            if (step_o !== w.step)
                report($sformatf("word %0d step_pulse %b, want %b", words_seen, step_o, w.step));
            if (dir_o !== w.dir)
                report($sformatf("word %0d direction_cw %b, want %b", words_seen, dir_o, w.dir));
            if (pos_o !== w.pos)
                report($sformatf("word %0d position %0d, want %0d", words_seen,
                                 $signed(pos_o), $signed(w.pos)));
            if (stage_o !== w.stage)
                report($sformatf("word %0d phase %0d, want %0d", words_seen, stage_o, w.stage));
            if (shut_o !== w.shut)
                report($sformatf("word %0d shutdown_pending %b, want %b", words_seen,
                                 shut_o, w.shut));
        endtask
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [31:0]                   now_us = '0;
    logic [31:0]                   now_ms = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          step_pulse;
    logic                          direction_cw;
    logic signed [POS_W-1:0]       position;
    logic [2:0]                    phase;
    logic                          shutdown_pending;
    logic                          cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;

    int unsigned                   send_idle_pct = 0;
    int unsigned                   stall_pct = 0;
    int unsigned                   cycle_count = 0;
    logic [31:0]                   ms_clock = '0;
    stroke_tracker                 tracker = new();

    sinusoidal_stepper_stroke_sequencer #(
        .TABLE_SIZE     (STROKE_TABLE),
        .SINE_FRAC_BITS (SINE_BITS)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .now_us           (now_us),
        .now_ms           (now_ms),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .step_pulse       (step_pulse),
        .direction_cw     (direction_cw),
        .position         (position),
        .phase            (phase),
        .shutdown_pending (shutdown_pending),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[sinusoidal_stepper_stroke_sequencer] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_word(step_pulse, direction_cw, position, phase, shutdown_pending);
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic push_timestamp(input logic [31:0] us, input logic [31:0] ms);
        in_valid <= 1'b1;
        now_us <= us;
        now_ms <= ms;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.accept_timestamp(us, ms);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        tracker.set_reg(idx, data);
    endtask

    // Narrow registers get junk in the unused upper bits of the data word
    task automatic load_setting(input logic [15:0] sf, input logic [15:0] ss,
                                input logic [15:0] df, input logic [15:0] ds,
                                input logic [15:0] rt, input logic [15:0] pk,
                                input logic [31:0] run, input logic [7:0] tol);
        write_reg(CFG_SYS_FAST, {16'($urandom), sf});
        write_reg(CFG_SYS_SLOW, {16'($urandom), ss});
        write_reg(CFG_DIA_FAST, {16'($urandom), df});
        write_reg(CFG_DIA_SLOW, {16'($urandom), ds});
        write_reg(CFG_RETURN, {16'($urandom), rt});
        write_reg(CFG_PARK, {16'($urandom), pk});
        write_reg(CFG_RUNTIME, run);
        write_reg(CFG_HOME_TOL, {24'($urandom), tol});
        cfg_we <= 1'b0;
    endtask

    // Drop valid and drain every outstanding word
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.due_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly land on or just past the step threshold, sometimes short of it or anywhere
    function automatic logic [31:0] next_stamp();
        int unsigned gap;
        int unsigned pick;
        gap = tracker.pace();
        pick = $urandom_range(99);
        if (pick < 8 && gap > 0)
            return tracker.last_us + $urandom_range(0, gap - 1);
        if (pick < 20)
            return $urandom();
        return tracker.last_us + gap + $urandom_range(0, 2);
    endfunction

    function automatic bit stream_done(input stream_end_t stop_on);
        case (stop_on)
            STOP_STROKE: return tracker.strokes >= 1 && tracker.stage == PH_DONE;
            STOP_HOLD:   return tracker.stage == PH_HOLD;
            default:     return 1;
        endcase
    endfunction

    task automatic run_stream(input int unsigned min_items, input stream_end_t stop_on);
        int unsigned n;
        n = 0;
        while (n < STREAM_CAP && !(n >= min_items && stream_done(stop_on)))
        begin
            ms_clock = ms_clock + $urandom_range(0, 2);
            push_timestamp(next_stamp(), ms_clock);
            n++;
        end
    endtask

    initial
    begin
        int unsigned gap;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first word latches the start time at all ones; the next one wraps it
        push_timestamp(32'h0000_0000, 32'hFFFF_FFFF);
        push_timestamp(32'hFFFF_FFFF, 32'h0000_0000);
        for (int i = 0; i < 18; i++)
        begin
            gap = tracker.pace();
            ms_clock = ms_clock + 1;
            push_timestamp(tracker.last_us + gap - (((i % 2) == 0 && gap > 0) ? 1 : 0),
                           ms_clock);
        end

        run_stream(400, STOP_COUNT);

        settle();
        send_idle_pct = 83;
        // full-range systole, diastole with fast above slow
        load_setting(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF,
                     32'hFFFF_FFFF, 8'hFF);
        run_stream(400, STOP_COUNT);

        settle();
        send_idle_pct = 0;
        stall_pct = 83;
        load_setting(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, RST_RUNTIME, 8'd0);
        run_stream(400, STOP_COUNT);

        settle();
        send_idle_pct = 28;
        stall_pct = 28;
        load_setting(16'($urandom_range(0, 400)), 16'($urandom_range(0, 2000)),
                     16'($urandom_range(0, 400)), 16'($urandom_range(0, 2000)),
                     16'($urandom), 16'($urandom), 32'($urandom_range(100000, 32'hFFFF_FFFF)),
                     8'($urandom));
        // finish the first stroke and stop in cycle-done
        run_stream(1, STOP_STROKE);

        // expire the runtime while in cycle-done: shut down at once, then hold
        settle();
        write_reg(CFG_RUNTIME, 32'd0);
        cfg_we <= 1'b0;
        run_stream(100, STOP_HOLD);
        run_stream(480, STOP_COUNT);

        settle();
        if (tracker.mismatches == 0 && tracker.due_words.size() == 0)
            $display("[sinusoidal_stepper_stroke_sequencer] OK");
        else
            $display("[sinusoidal_stepper_stroke_sequencer] ERROR");
        $finish;
    end

endmodule

/* sinusoidal_stepper_stroke_sequencer.f */
+incdir+rtl/core
rtl/core/sss_pkg.sv
rtl/core/sss_sine_rom.sv
rtl/core/sss_profile_delay.sv
rtl/core/sinusoidal_stepper_stroke_sequencer.sv
test/sinusoidal_stepper_stroke_sequencer_test.sv
